### hw/rtl/clook_pkg.sv
// Shared types and constants of the C-LOOK disk request scheduler.
// Holds request and status codes, field widths and the controller state type.
// No dependencies.
package clook_pkg;

	// widths of the channel fields
	localparam int CYL_FIELD_W   = 16;
	localparam int COUNT_FIELD_W = 5;

	// request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SERVE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_INSERTED = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_SERVED   = 2'd2,
		STATUS_EMPTY    = 2'd3
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_SCAN,
		S_FLUSH,
		S_FINISH
	} ctrl_state_t;

endpackage

### hw/rtl/clook_if.sv
// Request and response channel interfaces of the C-LOOK scheduler.
// Valid/ready handshake; a transfer happens when valid and ready are high.
// Depends on clook_pkg.
interface clook_req_if
	import clook_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [CYL_FIELD_W-1:0] cylinder;

	modport source(output valid, output req_type, output cylinder, input ready);
	modport sink(input valid, input req_type, input cylinder, output ready);
endinterface

interface clook_rsp_if
	import clook_pkg::*;
;
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic [CYL_FIELD_W-1:0]   served_cylinder;
	logic [COUNT_FIELD_W-1:0] pending_count;

	modport source(output valid, output status, output served_cylinder,
		output pending_count, input ready);
	modport sink(input valid, input status, input served_cylinder,
		input pending_count, output ready);
endinterface

### hw/rtl/clook_disk_request_scheduler.sv
// C-LOOK disk request scheduler, top level.
// Request table in a one-port synchronous memory, valid bits in flip-flops.
// Depends on clook_pkg and the interfaces in clook_if.sv.

// Takes one request at a time and returns exactly one response per request.
// An insert walks the valid bits from slot 0 and writes the lowest free slot.
// A serve reads every slot of the table memory, one per cycle through its
// single read port, and keeps the nearest cylinder at or above the head and
// the lowest one. A full insert or an empty serve skips the walk and the scan
// and goes straight to the finish state. The response sits in an output
// register, so the next request is taken while a response waits. The head
// starts at cylinder 0; no clearing pass is needed after reset.
module clook_disk_request_scheduler
	import clook_pkg::*;
#(
	parameter int TABLE_DEPTH   = 16,
	parameter int CYLINDER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	clook_req_if.sink     request,
	clook_rsp_if.source   response
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_DEPTH);

	ctrl_state_t state_q, state_d;

	logic [CYLINDER_BITS-1:0] mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]   valid_q;
	logic [CYLINDER_BITS-1:0] head_q;
	logic [CNT_W-1:0]         count_q, cnt_next;
	logic [IDX_W-1:0]         idx_q;
	logic [CYLINDER_BITS-1:0] cyl_q;
	status_t                  fin_status_q;

	// read pipeline
	logic                     rd_vld_s1;
	logic                     entry_vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic [CYLINDER_BITS-1:0] rd_data_s1;

	// scan accumulators
	logic                     above_found_q, low_found_q;
	logic [CYLINDER_BITS-1:0] above_val_q, low_val_q;
	logic [IDX_W-1:0]         above_idx_q, low_idx_q;
	logic [CYLINDER_BITS-1:0] pick_val;
	logic [IDX_W-1:0]         pick_idx;

	// output register
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic [CYL_FIELD_W-1:0]   out_cyl_q;
	logic [COUNT_FIELD_W-1:0] out_count_q;

	// control strobes
	logic    in_xfer, out_free;
	logic    mem_we, ins_commit, srv_commit, rd_issue, out_load, idx_inc;
	status_t out_status;

	assign request.ready = (state_q == S_IDLE);
	assign in_xfer       = request.valid && request.ready;
	assign out_free      = !out_valid_q || response.ready;

	assign pick_val = above_found_q ? above_val_q : low_val_q;
	assign pick_idx = above_found_q ? above_idx_q : low_idx_q;

	// next state and strobes
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		ins_commit = 1'b0;
		srv_commit = 1'b0;
		rd_issue   = 1'b0;
		out_load   = 1'b0;
		idx_inc    = 1'b0;
		out_status = STATUS_INSERTED;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (request.req_type == REQ_INSERT) begin
						state_d = (count_q == FULL_CNT) ? S_FINISH : S_INSERT;
					end else begin
						state_d = (count_q == '0) ? S_FINISH : S_SCAN;
					end
				end
			end
			S_INSERT: begin
				if (!valid_q[idx_q]) begin
					if (out_free) begin
						mem_we     = 1'b1;
						ins_commit = 1'b1;
						out_load   = 1'b1;
						out_status = STATUS_INSERTED;
						state_d    = S_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_SCAN: begin
				rd_issue = 1'b1;
				idx_inc  = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_status = fin_status_q;
					srv_commit = (fin_status_q == STATUS_SERVED);
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// latch the request and pick the status of the short paths
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cyl_q <= CYLINDER_BITS'(request.cylinder);
			if (request.req_type == REQ_INSERT) begin
				fin_status_q <= STATUS_FULL;
			end else begin
				fin_status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_SERVED;
			end
		end
	end

	// slot index: restart on each transfer, advance while walking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_xfer) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// table memory: write on insert, read one slot per cycle on serve
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= cyl_q;
		end
		rd_data_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1    <= 1'b0;
			entry_vld_s1 <= 1'b0;
			idx_s1       <= '0;
		end else begin
			rd_vld_s1    <= rd_issue;
			entry_vld_s1 <= valid_q[idx_q];
			idx_s1       <= idx_q;
		end
	end

	// track nearest at/above head and lowest; first slot wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_found_q <= 1'b0;
			low_found_q   <= 1'b0;
		end else if (in_xfer) begin
			above_found_q <= 1'b0;
			low_found_q   <= 1'b0;
		end else if (rd_vld_s1 && entry_vld_s1) begin
			if (rd_data_s1 >= head_q && (!above_found_q || rd_data_s1 < above_val_q)) begin
				above_found_q <= 1'b1;
			end
			if (!low_found_q || rd_data_s1 < low_val_q) begin
				low_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && entry_vld_s1) begin
			if (rd_data_s1 >= head_q && (!above_found_q || rd_data_s1 < above_val_q)) begin
				above_val_q <= rd_data_s1;
				above_idx_q <= idx_s1;
			end
			if (!low_found_q || rd_data_s1 < low_val_q) begin
				low_val_q <= rd_data_s1;
				low_idx_q <= idx_s1;
			end
		end
	end

	// pending count after this item
	always_comb begin
		cnt_next = count_q;
		if (ins_commit) begin
			cnt_next = count_q + CNT_W'(1);
		end else if (srv_commit) begin
			cnt_next = count_q - CNT_W'(1);
		end
	end

	// commit: valid bits, head, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= cnt_next;
			if (ins_commit) begin
				valid_q[idx_q] <= 1'b1;
			end
			if (srv_commit) begin
				valid_q[pick_idx] <= 1'b0;
				head_q            <= pick_val;
			end
		end
	end

	// response register: load when a result is ready, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status;
			out_cyl_q    <= srv_commit ? CYL_FIELD_W'(pick_val) : '0;
			out_count_q  <= COUNT_FIELD_W'(cnt_next);
		end
	end

	assign response.valid           = out_valid_q;
	assign response.status          = out_status_q;
	assign response.served_cylinder = out_cyl_q;
	assign response.pending_count   = out_count_q;

endmodule

### hw/rtl/clook_checker.sv
// Port-level assertions for the C-LOOK scheduler and their bind.
// Watches only the request and response channels of the top level.
// Depends on clook_pkg.
module clook_checker
	import clook_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input status_t                  status,
	input logic [CYL_FIELD_W-1:0]   served_cylinder,
	input logic [COUNT_FIELD_W-1:0] pending_count
);

	// hold a stalled response
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(served_cylinder) && $stable(pending_count))
		else $error("response changed while stalled");

	// one request in flight: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	// only a serve carries a cylinder
	a_cyl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_SERVED |-> served_cylinder == '0)
		else $error("cylinder reported on a non-serve response");

	// an empty serve leaves nothing pending
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_EMPTY |-> pending_count == '0)
		else $error("empty response with requests pending");

endmodule

bind clook_disk_request_scheduler clook_checker u_clook_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (request.valid),
	.in_ready        (request.ready),
	.out_valid       (response.valid),
	.out_ready       (response.ready),
	.status          (response.status),
	.served_cylinder (response.served_cylinder),
	.pending_count   (response.pending_count)
);

### tb/tb_clook_disk_request_scheduler.sv
// Self-checking testbench for the C-LOOK disk request scheduler.
// Drives insert and serve requests, predicts every response, compares in order.
// Depends on clook_pkg, clook_if.sv and clook_disk_request_scheduler.
module tb_clook_disk_request_scheduler
	import clook_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS     = 16;
	localparam int N_RANDOM  = 540;
	localparam int DRAIN_CYC = 40;

	typedef struct packed {
		logic                   kind;
		logic [CYL_FIELD_W-1:0] cyl;
	} disk_req_t;

	typedef struct packed {
		status_t                  status;
		logic [CYL_FIELD_W-1:0]   cyl;
		logic [COUNT_FIELD_W-1:0] count;
	} disk_rsp_t;

	logic clk;
	logic arst_n;

	clook_req_if req_ch();
	clook_rsp_if rsp_ch();

	clook_disk_request_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (req_ch.sink),
		.response (rsp_ch.source)
	);

	// scheduler state as the testbench sees it
	logic [CYL_FIELD_W-1:0] slot_cyl [SLOTS];
	bit                     slot_busy [SLOTS];
	logic [CYL_FIELD_W-1:0] head_cyl;
	int                     queued_reqs;

	disk_req_t req_backlog[$];
	disk_rsp_t awaited_resp[$];

	int n_accepted;
	int n_mismatch;
	bit rsp_hold;

	// clock and reset
	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// no idling on either side while this many transfers are in a window
	function automatic bit calm_window();
		return n_accepted >= 330 && n_accepted < 420;
	endfunction

	// compute the response to one request and advance the scheduler state
	function automatic disk_rsp_t clook_schedule(input logic kind,
			input logic [CYL_FIELD_W-1:0] cyl);
		disk_rsp_t r;
		int above;
		int lowest;
		int pick;
		r.status = STATUS_INSERTED;
		r.cyl    = '0;
		above    = -1;
		lowest   = -1;
		if (kind == REQ_INSERT) begin
			r.status = STATUS_FULL;
			for (int i = 0; i < SLOTS; i++) begin
				if (!slot_busy[i]) begin
					slot_cyl[i]  = cyl;
					slot_busy[i] = 1'b1;
					queued_reqs++;
					r.status = STATUS_INSERTED;
					break;
				end
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_busy[i]) begin
					if (slot_cyl[i] >= head_cyl &&
						(above < 0 || slot_cyl[i] < slot_cyl[above]))
						above = i;
					if (lowest < 0 || slot_cyl[i] < slot_cyl[lowest])
						lowest = i;
				end
			end
			if (lowest < 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				// wrap to the lowest pending cylinder when nothing lies ahead
				pick            = (above >= 0) ? above : lowest;
				head_cyl        = slot_cyl[pick];
				slot_busy[pick] = 1'b0;
				queued_reqs--;
				r.status = STATUS_SERVED;
				r.cyl    = head_cyl;
			end
		end
		r.count = queued_reqs[COUNT_FIELD_W-1:0];
		return r;
	endfunction

	// request driver: predict each transfer, then offer the next backlog item
	always @(posedge clk or negedge arst_n) begin : drive_req
		disk_req_t item;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= REQ_INSERT;
			req_ch.cylinder <= '0;
			head_cyl    = '0;
			queued_reqs = 0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_busy[i] = 1'b0;
				slot_cyl[i]  = '0;
			end
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				awaited_resp.push_back(clook_schedule(req_ch.req_type, req_ch.cylinder));
				n_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_backlog.size() != 0 &&
					(calm_window() || $urandom_range(99) >= 23)) begin
					item = req_backlog.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.req_type <= item.kind;
					req_ch.cylinder <= item.cyl;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response ready: random stalls plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !rsp_hold && (calm_window() || $urandom_range(99) >= 23);
		end
	end

	// response monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin : check_rsp
		disk_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_resp.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: unexpected response status=%0d cyl=%0d count=%0d",
						$realtime, rsp_ch.status, rsp_ch.served_cylinder,
						rsp_ch.pending_count);
			end else begin
				want = awaited_resp.pop_front();
				if (rsp_ch.status !== want.status ||
					rsp_ch.served_cylinder !== want.cyl ||
					rsp_ch.pending_count !== want.count) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"%0t: mismatch expected status=%0d cyl=%0d count=%0d",
							" actual status=%0d cyl=%0d count=%0d"}, $realtime,
							want.status, want.cyl, want.count, rsp_ch.status,
							rsp_ch.served_cylinder, rsp_ch.pending_count);
				end
			end
		end
	end

	// hold off the receiver long enough that the block stalls its input
	initial begin : hold_off
		int k;
		while (n_accepted < 120) @(posedge clk);
		rsp_hold <= 1'b1;
		for (k = 0; k < 400; k++) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	task automatic add_req(input logic kind, input logic [CYL_FIELD_W-1:0] cyl);
		disk_req_t item;
		item.kind = kind;
		item.cyl  = cyl;
		req_backlog.push_back(item);
	endtask

	// bursts that lean toward inserts, serves or neither, to reach full and empty
	task automatic add_random(input int n);
		int left;
		int ins_pct;
		logic [CYL_FIELD_W-1:0] last_cyl;
		logic [CYL_FIELD_W-1:0] c;
		left     = 0;
		ins_pct  = 50;
		last_cyl = '0;
		for (int i = 0; i < n; i++) begin
			if (left == 0) begin
				left = $urandom_range(40, 8);
				case ($urandom_range(2))
					0:       ins_pct = 85;
					1:       ins_pct = 20;
					default: ins_pct = 50;
				endcase
			end
			left--;
			case ($urandom_range(9))
				0:       c = '0;
				1:       c = '1;
				2, 3:    c = CYL_FIELD_W'($urandom_range(40));
				4:       c = '1 - CYL_FIELD_W'($urandom_range(40));
				5:       c = last_cyl;
				default: c = CYL_FIELD_W'($urandom);
			endcase
			last_cyl = c;
			if ($urandom_range(99) < ins_pct)
				add_req(REQ_INSERT, c);
			else
				add_req(REQ_SERVE, CYL_FIELD_W'($urandom));
		end
	endtask

	// hold until every queued request has been taken and answered
	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_ch.valid) @(posedge clk);
		while (awaited_resp.size() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		@(posedge arst_n);

		// directed: empty serve, head match, duplicates, top cylinder, wrap
		add_req(REQ_SERVE, 16'h1234);
		add_req(REQ_INSERT, 16'hFFFF);
		add_req(REQ_INSERT, 16'h5555);
		add_req(REQ_INSERT, 16'h5555);
		add_req(REQ_INSERT, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'hFFFF);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_INSERT, 16'h8000);
		add_req(REQ_INSERT, 16'h0010);
		add_req(REQ_INSERT, 16'hAAAA);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		add_req(REQ_SERVE, 16'h0000);
		wait_idle();

		// random, with a pause for a full drain in the middle
		add_random(N_RANDOM / 2);
		wait_idle();
		add_random(N_RANDOM - N_RANDOM / 2);
		wait_idle();

		repeat (DRAIN_CYC) @(posedge clk);
		if (n_mismatch == 0) begin
			$display("[clook_disk_request_scheduler] OK");
		end else begin
			$display("[clook_disk_request_scheduler] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[clook_disk_request_scheduler] ERROR");
		$finish;
	end

endmodule

### files.f
hw/rtl/clook_pkg.sv
hw/rtl/clook_if.sv
hw/rtl/clook_disk_request_scheduler.sv
hw/rtl/clook_checker.sv
tb/tb_clook_disk_request_scheduler.sv
